@@ rtl/vem_pkg.sv @@
// ----------------------------------------------------------------------------
// vem_pkg
// Shared constants and helpers of the volume error metrics block.
// ----------------------------------------------------------------------------
package vem_pkg;

    localparam int COUNT_BITS_DEF = 24;

    // opcodes
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_ACC  = 1'b1;

    // special flags
    localparam logic [1:0] SPEC_FINITE  = 2'd0;
    localparam logic [1:0] SPEC_POS_INF = 2'd1;
    localparam logic [1:0] SPEC_NEG_INF = 2'd2;

    // metric codes
    localparam logic [3:0] MET_REF_MIN   = 4'd0;
    localparam logic [3:0] MET_CMP_MAX   = 4'd3;
    localparam logic [3:0] MET_RULE_BASE = 4'd4;
    localparam logic [3:0] MET_PSNR_LAST = 4'd12;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // decibels per octave in Q.32, split in two words
    localparam logic [31:0] DB_K0 = 32'd44237977;
    localparam logic [31:0] DB_K1 = 32'd3;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

@@ rtl/vem_in_if.sv @@
// ----------------------------------------------------------------------------
// vem_in_if
// Input item channel: voxel pair with opcode and end of pass mark.
// ----------------------------------------------------------------------------
interface vem_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] ref_sample;
    logic signed [31:0] cmp_sample;
    logic               last;

    modport source (output valid, opcode, ref_sample, cmp_sample, last, input ready);
    modport sink   (input valid, opcode, ref_sample, cmp_sample, last, output ready);
endinterface

@@ rtl/vem_out_if.sv @@
// ----------------------------------------------------------------------------
// vem_out_if
// Result item channel: metric code, value and flags.
// ----------------------------------------------------------------------------
interface vem_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         metric;
    logic signed [63:0] value;
    logic [1:0]         special;
    logic               final_res;

    modport source (output valid, metric, value, special, final_res, input ready);
    modport sink   (input valid, metric, value, special, final_res, output ready);
endinterface

@@ rtl/volume_error_metrics_top.sv @@
// ----------------------------------------------------------------------------
// volume_error_metrics_top
// Range scan and error accumulation over voxel pairs; MSE, SNR and PSNR
// under three normalisation rules, sequenced on one shared multiplier.
//
// channel  dir  handshake    payload
// i_in     in   valid/ready  opcode, ref_sample, cmp_sample, last
// o_res    out  valid/ready  metric, value, special, final_res
//
// a scan item updates the range trackers as it is accepted; an accumulate item
// needs 24 products on the shared multiplier (3 normalisations, 6 squares)
// end of a scan pass: 4 results, then up to 2 divisions
// end of an accumulate pass: up to 8 logarithms, 3 divisions
// synchronous active-low reset; i_in is not ready while an item is at work
// an output register holds a result until o_res.ready
// ----------------------------------------------------------------------------
module volume_error_metrics_top #(
    parameter int COUNT_BITS = vem_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vem_in_if.sink    i_in,
    vem_out_if.source o_res
);
    import vem_pkg::*;

    localparam int CW = COUNT_BITS + 1;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_NORM  = 5'd1;
    localparam logic [4:0] ST_SQ    = 5'd2;
    localparam logic [4:0] ST_RNG   = 5'd3;
    localparam logic [4:0] ST_REC   = 5'd4;
    localparam logic [4:0] ST_RECW  = 5'd5;
    localparam logic [4:0] ST_EMIT  = 5'd6;
    localparam logic [4:0] ST_WAIT  = 5'd7;
    localparam logic [4:0] ST_A_LN  = 5'd8;
    localparam logic [4:0] ST_A_LNW = 5'd9;
    localparam logic [4:0] ST_A_DIV = 5'd10;
    localparam logic [4:0] ST_A_MSE = 5'd11;
    localparam logic [4:0] ST_A_CHK = 5'd12;
    localparam logic [4:0] ST_A_INF = 5'd13;
    localparam logic [4:0] ST_A_LE  = 5'd14;
    localparam logic [4:0] ST_A_LS  = 5'd15;
    localparam logic [4:0] ST_A_PS  = 5'd16;
    localparam logic [4:0] ST_A_PK  = 5'd17;
    localparam logic [4:0] ST_A_PKL = 5'd18;
    localparam logic [4:0] ST_A_PDB = 5'd19;
    localparam logic [4:0] ST_A_NXT = 5'd20;
    localparam logic [4:0] ST_DB    = 5'd21;

    function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] n);
        logic signed [63:0] r;
        r = n;
        if (n < 0) begin
            r = '0;
        end else if (n > 64'sh1_0000_0000) begin
            r = 64'sh1_0000_0000;
        end
        return r;
    endfunction

    logic [4:0]         r_state;
    logic [4:0]         r_ret;
    logic [2:0]         r_step;
    logic [2:0]         r_idx;
    logic [1:0]         r_j;
    logic signed [31:0] r_ref_lo, r_ref_hi, r_cmp_lo, r_cmp_hi;
    logic [47:0]        r_rc [2];
    logic [63:0]        r_ssum [3];
    logic [63:0]        r_esum [3];
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_ref, r_cmp;
    logic               r_last;
    logic signed [63:0] r_n [3];
    logic [95:0]        r_acc;
    logic [63:0]        r_ln, r_le, r_la;
    logic [3:0]         r_em_metric;
    logic [63:0]        r_em_val;
    logic [1:0]         r_em_spec;
    logic               r_em_fin;
    logic               r_ov;
    logic [3:0]         r_om;
    logic [63:0]        r_oval;
    logic [1:0]         r_ospec;
    logic               r_ofin;

    logic [CW-1:0]      n_count;
    logic signed [31:0] n_ref_lo, n_ref_hi, n_cmp_lo, n_cmp_hi;
    logic               accept, out_free;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_prod;
    logic               div_start, div_busy, log_start, log_busy;
    logic [63:0]        div_dvd, div_q, log_x, log_res;
    logic [32:0]        div_dvs;
    logic [31:0]        log_sq_op;
    // normalisation
    logic signed [31:0] nv_v, nv_low;
    logic [47:0]        nv_rc;
    logic [32:0]        nv_d;
    logic               nv_neg;
    logic [31:0]        nv_u;
    logic [63:0]        nv_mag, nv_res;
    // squares
    logic signed [63:0] sq_a, sq_b;
    logic [63:0]        sq_x, sq_val;
    // decibels
    logic               db_neg;
    logic [63:0]        db_d, db_r, db_val;
    // reciprocal and peak
    logic signed [32:0] rec_r;
    logic               rec_pos;
    logic [31:0]        pk;
    logic [63:0]        e_j, s_j;
    logic [3:0]         met_mse;

    vem_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    vem_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    vem_log u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .i_prod  (mul_prod),
        .o_sq_op (log_sq_op),
        .o_busy  (log_busy),
        .o_res   (log_res)
    );

    assign accept   = i_in.valid && (r_state == ST_IDLE);
    assign out_free = !r_ov || o_res.ready;

    always_comb begin
        n_count = r_count[COUNT_BITS] ? r_count : r_count + CW'(1);
        // range trackers restart at the first scan item of a pass
        n_ref_lo = (r_count == '0) ? Q_MAX : r_ref_lo;
        n_ref_hi = (r_count == '0) ? Q_MIN : r_ref_hi;
        n_cmp_lo = (r_count == '0) ? Q_MAX : r_cmp_lo;
        n_cmp_hi = (r_count == '0) ? Q_MIN : r_cmp_hi;
        if (i_in.ref_sample < n_ref_lo) n_ref_lo = i_in.ref_sample;
        if (i_in.ref_sample > n_ref_hi) n_ref_hi = i_in.ref_sample;
        if (i_in.cmp_sample < n_cmp_lo) n_cmp_lo = i_in.cmp_sample;
        if (i_in.cmp_sample > n_cmp_hi) n_cmp_hi = i_in.cmp_sample;
    end

    always_comb begin
        nv_v   = (r_idx == 3'd0) ? r_ref : r_cmp;
        nv_low = (r_idx == 3'd2) ? r_cmp_lo : r_ref_lo;
        nv_rc  = (r_idx == 3'd2) ? r_rc[1] : r_rc[0];
        nv_d   = {nv_v[31], nv_v} - {nv_low[31], nv_low};
        nv_neg = nv_d[32];
        nv_u   = nv_neg ? 32'(-nv_d) : nv_d[31:0];
        nv_mag = (r_acc[95:79] != '0) ? SAT_POS : {1'b0, r_acc[78:16]};
        if (nv_rc == '0) begin
            nv_res = '0;
        end else begin
            nv_res = nv_neg ? -nv_mag : nv_mag;
        end
    end

    always_comb begin
        case (r_idx[2:1])
            2'd0: begin
                sq_a = clamp_unit(r_n[0]);
                sq_b = clamp_unit(r_n[1]);
            end
            2'd1: begin
                sq_a = r_n[0];
                sq_b = r_n[2];
            end
            default: begin
                sq_a = {{16{r_ref[31]}}, r_ref, 16'd0};
                sq_b = {{16{r_cmp[31]}}, r_cmp, 16'd0};
            end
        endcase
        if (!r_idx[0]) sq_b = '0;
        sq_x   = (sq_a >= sq_b) ? 64'(sq_a - sq_b) : 64'(sq_b - sq_a);
        sq_val = (sq_x[63:48] != '0) ? '1 : r_acc[95:32];
    end

    always_comb begin
        db_neg = r_la < r_le;
        db_d   = db_neg ? r_le - r_la : r_la - r_le;
        db_r   = r_acc[95:32];
        db_val = db_neg ? -db_r : db_r;
    end

    always_comb begin
        if (r_idx[0]) begin
            rec_r = {r_cmp_hi[31], r_cmp_hi} - {r_cmp_lo[31], r_cmp_lo};
        end else begin
            rec_r = {r_ref_hi[31], r_ref_hi} - {r_ref_lo[31], r_ref_lo};
        end
        rec_pos = !rec_r[32] && (rec_r != '0);
        pk      = r_ref_hi[31] ? 32'(-r_ref_hi) : r_ref_hi;
        e_j     = r_esum[r_j];
        s_j     = r_ssum[r_j];
        met_mse = MET_RULE_BASE + 4'(r_j) * 4'd3;
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_NORM: begin
                mul_a = nv_u;
                mul_b = (r_step == 3'd0) ? nv_rc[31:0] : {16'd0, nv_rc[47:32]};
            end
            ST_SQ: begin
                mul_a = (r_step == 3'd2) ? {16'd0, sq_x[47:32]} : sq_x[31:0];
                mul_b = (r_step == 3'd0) ? sq_x[31:0] : {16'd0, sq_x[47:32]};
            end
            ST_DB: begin
                mul_a = (r_step < 3'd2) ? db_d[31:0] : db_d[63:32];
                mul_b = r_step[0] ? DB_K1 : DB_K0;
            end
            ST_A_PK: begin
                mul_a = pk;
                mul_b = pk;
            end
            ST_WAIT: begin
                mul_a = log_sq_op;
                mul_b = log_sq_op;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_dvd   = e_j;
        div_dvs   = 33'(r_count);
        log_start = 1'b0;
        log_x     = e_j;
        case (r_state)
            ST_REC: begin
                div_start = !r_idx[1] && rec_pos;
                div_dvd   = 64'h0001_0000_0000_0000;
                div_dvs   = rec_r;
            end
            ST_A_DIV: div_start = 1'b1;
            ST_A_LN: begin
                log_start = 1'b1;
                log_x     = 64'(r_count);
            end
            ST_A_CHK: log_start = e_j != '0;
            ST_A_LE: begin
                log_start = s_j != '0;
                log_x     = s_j;
            end
            ST_A_PKL: begin
                log_start = 1'b1;
                log_x     = mul_prod;
            end
            default: begin
                div_start = 1'b0;
                log_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ov     <= 1'b0;
            r_ref_lo <= Q_MAX;
            r_cmp_lo <= Q_MAX;
            r_ref_hi <= Q_MIN;
            r_cmp_hi <= Q_MIN;
            r_rc[0]  <= '0;
            r_rc[1]  <= '0;
            r_count  <= '0;
            for (int k = 0; k < 3; k++) begin
                r_ssum[k] <= '0;
                r_esum[k] <= '0;
            end
        end else begin
            if (r_ov && o_res.ready) r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_count <= n_count;
                        if (i_in.opcode == OP_SCAN) begin
                            r_ref_lo <= n_ref_lo;
                            r_ref_hi <= n_ref_hi;
                            r_cmp_lo <= n_cmp_lo;
                            r_cmp_hi <= n_cmp_hi;
                            if (i_in.last) begin
                                r_idx   <= '0;
                                r_state <= ST_RNG;
                            end
                        end else begin
                            r_ref   <= i_in.ref_sample;
                            r_cmp   <= i_in.cmp_sample;
                            r_last  <= i_in.last;
                            r_idx   <= '0;
                            r_step  <= '0;
                            r_state <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: r_acc <= nv_u[0] & 1'b0 ? '0 : '0;
                        3'd1: r_acc <= 96'(mul_prod);
                        3'd2: r_acc <= r_acc + {mul_prod, 32'd0};
                        default: begin
                            r_n[r_idx[1:0]] <= nv_res;
                            r_step          <= '0;
                            if (r_idx == 3'd2) begin
                                r_idx   <= '0;
                                r_state <= ST_SQ;
                            end else begin
                                r_idx <= r_idx + 3'd1;
                            end
                        end
                    endcase
                end
                ST_SQ: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: r_acc <= '0;
                        3'd1: r_acc <= 96'(mul_prod);
                        3'd2: r_acc <= r_acc + 96'({mul_prod, 33'd0});
                        3'd3: r_acc <= r_acc + 96'({mul_prod, 64'd0});
                        default: begin
                            if (r_idx[0]) begin
                                r_esum[r_idx[2:1]] <= sat_add64(r_esum[r_idx[2:1]], sq_val);
                            end else begin
                                r_ssum[r_idx[2:1]] <= sat_add64(r_ssum[r_idx[2:1]], sq_val);
                            end
                            r_step <= '0;
                            if (r_idx == 3'd5) begin
                                r_state <= r_last ? ST_A_LN : ST_IDLE;
                            end else begin
                                r_idx <= r_idx + 3'd1;
                            end
                        end
                    endcase
                end
                ST_RNG: begin
                    r_em_metric <= MET_REF_MIN + 4'(r_idx[1:0]);
                    case (r_idx[1:0])
                        2'd0:    r_em_val <= 64'(r_ref_lo);
                        2'd1:    r_em_val <= 64'(r_ref_hi);
                        2'd2:    r_em_val <= 64'(r_cmp_lo);
                        default: r_em_val <= 64'(r_cmp_hi);
                    endcase
                    r_em_spec <= SPEC_FINITE;
                    r_em_fin  <= r_idx[1:0] == 2'd3;
                    r_ret     <= (r_idx[1:0] == 2'd3) ? ST_REC : ST_RNG;
                    r_idx     <= (r_idx[1:0] == 2'd3) ? 3'd0 : r_idx + 3'd1;
                    r_state   <= ST_EMIT;
                end
                ST_REC: begin
                    if (r_idx[1]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_ssum[k] <= '0;
                            r_esum[k] <= '0;
                        end
                        r_count <= '0;
                        r_state <= ST_IDLE;
                    end else if (rec_pos) begin
                        r_ret   <= ST_RECW;
                        r_state <= ST_WAIT;
                    end else begin
                        r_rc[r_idx[0]] <= '0;
                        r_idx          <= r_idx + 3'd1;
                    end
                end
                ST_RECW: begin
                    r_rc[r_idx[0]] <= div_q[48] ? '1 : div_q[47:0];
                    r_idx          <= r_idx + 3'd1;
                    r_state        <= ST_REC;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_om    <= r_em_metric;
                        r_oval  <= r_em_val;
                        r_ospec <= r_em_spec;
                        r_ofin  <= r_em_fin;
                        r_state <= r_ret;
                    end
                end
                ST_WAIT: begin
                    if (!div_busy && !log_busy) r_state <= r_ret;
                end
                ST_A_LN: begin
                    r_j     <= '0;
                    r_ret   <= ST_A_LNW;
                    r_state <= ST_WAIT;
                end
                ST_A_LNW: begin
                    r_ln    <= log_res;
                    r_state <= ST_A_DIV;
                end
                ST_A_DIV: begin
                    r_ret   <= ST_A_MSE;
                    r_state <= ST_WAIT;
                end
                ST_A_MSE: begin
                    r_em_metric <= met_mse;
                    r_em_val    <= div_q[63] ? SAT_POS : div_q;
                    r_em_spec   <= SPEC_FINITE;
                    r_em_fin    <= 1'b0;
                    r_ret       <= ST_A_CHK;
                    r_state     <= ST_EMIT;
                end
                ST_A_CHK: begin
                    if (e_j == '0) begin
                        r_em_metric <= met_mse + 4'd1;
                        r_em_val    <= SAT_POS;
                        r_em_spec   <= SPEC_POS_INF;
                        r_em_fin    <= 1'b0;
                        r_ret       <= ST_A_INF;
                        r_state     <= ST_EMIT;
                    end else begin
                        r_ret   <= ST_A_LE;
                        r_state <= ST_WAIT;
                    end
                end
                ST_A_INF: begin
                    r_em_metric <= met_mse + 4'd2;
                    r_em_val    <= SAT_POS;
                    r_em_spec   <= SPEC_POS_INF;
                    r_em_fin    <= r_j == 2'd2;
                    r_ret       <= ST_A_NXT;
                    r_state     <= ST_EMIT;
                end
                ST_A_LE: begin
                    r_le <= log_res;
                    if (s_j == '0) begin
                        r_em_metric <= met_mse + 4'd1;
                        r_em_val    <= SAT_NEG;
                        r_em_spec   <= SPEC_NEG_INF;
                        r_em_fin    <= 1'b0;
                        r_ret       <= ST_A_PS;
                        r_state     <= ST_EMIT;
                    end else begin
                        r_ret   <= ST_A_LS;
                        r_state <= ST_WAIT;
                    end
                end
                ST_A_LS: begin
                    r_la        <= log_res;
                    r_em_metric <= met_mse + 4'd1;
                    r_em_spec   <= SPEC_FINITE;
                    r_em_fin    <= 1'b0;
                    r_ret       <= ST_A_PS;
                    r_step      <= '0;
                    r_state     <= ST_DB;
                end
                ST_A_PS: begin
                    r_em_metric <= met_mse + 4'd2;
                    r_em_fin    <= r_j == 2'd2;
                    r_ret       <= ST_A_NXT;
                    r_step      <= '0;
                    if (r_j != 2'd2) begin
                        r_em_spec <= SPEC_FINITE;
                        r_la      <= r_ln + {32'd32, 32'd0};
                        r_state   <= ST_DB;
                    end else if (pk == '0) begin
                        r_em_val  <= SAT_NEG;
                        r_em_spec <= SPEC_NEG_INF;
                        r_state   <= ST_EMIT;
                    end else begin
                        r_em_spec <= SPEC_FINITE;
                        r_state   <= ST_A_PK;
                    end
                end
                ST_A_PK: begin
                    r_state <= ST_A_PKL;
                end
                ST_A_PKL: begin
                    r_ret   <= ST_A_PDB;
                    r_state <= ST_WAIT;
                end
                ST_A_PDB: begin
                    r_la    <= log_res + r_ln;
                    r_ret   <= ST_A_NXT;
                    r_step  <= '0;
                    r_state <= ST_DB;
                end
                ST_A_NXT: begin
                    if (r_j == 2'd2) begin
                        for (int k = 0; k < 3; k++) begin
                            r_ssum[k] <= '0;
                            r_esum[k] <= '0;
                        end
                        r_count <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= ST_A_DIV;
                    end
                end
                ST_DB: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd0: r_acc <= '0;
                        3'd1: r_acc <= 96'(mul_prod);
                        3'd2: r_acc <= r_acc + 96'({mul_prod, 32'd0});
                        3'd3: r_acc <= r_acc + 96'({mul_prod, 32'd0});
                        3'd4: r_acc <= r_acc + 96'({mul_prod, 64'd0});
                        default: begin
                            r_em_val <= db_val;
                            r_step   <= '0;
                            r_state  <= ST_EMIT;
                        end
                    endcase
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready      = r_state == ST_IDLE;
    assign o_res.valid     = r_ov;
    assign o_res.metric    = r_om;
    assign o_res.value     = r_oval;
    assign o_res.special   = r_ospec;
    assign o_res.final_res = r_ofin;
endmodule

@@ rtl/vem_mul.sv @@
// ----------------------------------------------------------------------------
// vem_mul
// Shared 32 x 32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module vem_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

@@ rtl/vem_div.sv @@
// ----------------------------------------------------------------------------
// vem_div
// Restoring divider, one quotient bit a cycle, 64 quotient bits a division.
// ----------------------------------------------------------------------------
module vem_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [32:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [32:0] r_div;
    logic [33:0] n_sh;
    logic [33:0] n_diff;
    logic        n_ge;

    always_comb begin
        n_sh   = {r_rem, r_q[63]};
        n_ge   = n_sh >= {1'b0, r_div};
        n_diff = n_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[32:0] : n_sh[32:0];
            r_q   <= {r_q[62:0], n_ge};
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

@@ rtl/vem_log.sv @@
// ----------------------------------------------------------------------------
// vem_log
// Base-two logarithm in Q.32: shift normalisation, then 32 squaring
// steps on the shared multiplier, each through states L_SQ0 and L_SQ1.
// ----------------------------------------------------------------------------
module vem_log (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    input  logic [63:0] i_prod,
    output logic [31:0] o_sq_op,
    output logic        o_busy,
    output logic [63:0] o_res
);
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ0  = 2'd2;
    localparam logic [1:0] L_SQ1  = 2'd3;

    logic [1:0]  r_state;
    logic [63:0] r_x;
    logic [5:0]  r_k;
    logic [31:0] r_m;
    logic [31:0] r_f;
    logic [4:0]  r_i;
    logic [63:0] r_res;
    logic [32:0] n_t;
    logic [31:0] n_m;
    logic [31:0] n_f;

    always_comb begin
        n_t = i_prod[63:31];
        n_f = r_f;
        if (n_t[32]) begin
            n_m = n_t[32:1];
            n_f[~r_i] = 1'b1;
        end else begin
            n_m = n_t[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        if (i_x == '0) begin
                            r_res <= '0;
                        end else begin
                            r_x     <= i_x;
                            r_k     <= 6'd63;
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_x[63]) begin
                        r_m     <= r_x[63:32];
                        r_f     <= '0;
                        r_i     <= '0;
                        r_state <= L_SQ0;
                    end else begin
                        r_x <= {r_x[62:0], 1'b0};
                        r_k <= r_k - 6'd1;
                    end
                end
                L_SQ0: begin
                    r_state <= L_SQ1;
                end
                L_SQ1: begin
                    r_m <= n_m;
                    r_f <= n_f;
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'd31) begin
                        r_res   <= {26'd0, r_k, n_f};
                        r_state <= L_IDLE;
                    end else begin
                        r_state <= L_SQ0;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_sq_op = r_m;
    assign o_busy  = r_state != L_IDLE;
    assign o_res   = r_res;
endmodule

@@ rtl/vem_chk.sv @@
// ----------------------------------------------------------------------------
// vem_chk
// Port-level checks of the volume error metrics block, bound to the top.
// ----------------------------------------------------------------------------
module vem_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_metric,
    input logic [63:0] i_value,
    input logic [1:0]  i_special,
    input logic        i_final
);
    import vem_pkg::*;

    // a waiting item is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value) && $stable(i_metric))
        else $error("result item dropped or changed under stall");

    // the last item of a pass always starts work
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input ready after end of pass");

    // the final flag only on the last metric of a pass
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_final |-> i_metric == MET_CMP_MAX || i_metric == MET_PSNR_LAST)
        else $error("final flag on wrong metric");

    // infinities only on decibel metrics
    a_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_special != SPEC_FINITE |->
            i_metric == 4'd5 || i_metric == 4'd6 || i_metric == 4'd8 ||
            i_metric == 4'd9 || i_metric == 4'd11 || i_metric == 4'd12)
        else $error("infinity flag on wrong metric");
endmodule

bind volume_error_metrics_top vem_chk u_vem_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_metric    (o_res.metric),
    .i_value     (o_res.value),
    .i_special   (o_res.special),
    .i_final     (o_res.final_res)
);

@@ test/tb_volume_error_metrics_top.sv @@
// ----------------------------------------------------------------------------
// tb_volume_error_metrics_top
// Self-checking bench for the volume error metrics block. A table of
// directed voxel pairs is followed by random scan and accumulate passes.
// Each accepted item goes through a bit-exact fixed-point predictor of the
// ranges, sums and decibel metrics. Results are checked in order against
// the expected queue. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_volume_error_metrics_top;
    import vem_pkg::*;

    typedef struct {
        logic               op;
        logic signed [31:0] ref_s;
        logic signed [31:0] cmp_s;
        logic               lst;
        bit                 typed;
        logic signed [31:0] t_rmin, t_rmax, t_cmin, t_cmax;
    } stim_row_t;

    typedef struct {
        logic [3:0]  metric;
        logic [63:0] value;
        logic [1:0]  special;
        logic        final_res;
    } metric_res_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 2000;
    localparam int N_RANDOM       = 120;

    logic i_clk;
    logic i_rst_n;

    vem_in_if  in_ch();
    vem_out_if res_ch();

    volume_error_metrics_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // predictor state
    logic signed [31:0] p_ref_low, p_ref_high, p_cmp_low, p_cmp_high;
    logic [47:0]        p_recip [2];
    logic [63:0]        p_sig [3];
    logic [63:0]        p_err [3];
    logic [24:0]        p_count;

    metric_res_t pred_q[$];
    metric_res_t pending_res[$];
    stim_row_t   dir_rows[$];

    int mismatches, unexpected, results_seen, items_sent, scan_ends, acc_ends;
    int idle_cycles, stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] norm_q(input logic signed [31:0] v,
            input logic signed [31:0] lo, input logic [47:0] rc);
        logic signed [63:0] d;
        logic [63:0]        u, mag;
        logic [127:0]       p;
        if (rc == 48'd0) return 64'sd0;
        d = 64'(v) - 64'(lo);
        u = (d < 0) ? 64'(-d) : 64'(d);
        p = 128'(u) * 128'(rc);
        mag = (p[127:80] != 0) ? SAT_POS : p[79:16];
        if (mag > SAT_POS) mag = SAT_POS;
        return (d < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] n);
        if (n < 0) return 64'sd0;
        if (n > 64'sh1_0000_0000) return 64'sh1_0000_0000;
        return n;
    endfunction

    function automatic logic [63:0] sq_diff(input logic signed [63:0] a,
            input logic signed [63:0] b);
        logic [63:0]  u;
        logic [127:0] p;
        u = (a >= b) ? 64'(a - b) : 64'(b - a);
        p = 128'(u) * 128'(u);
        return (p[127:96] != 0) ? '1 : p[95:32];
    endfunction

    function automatic logic [47:0] recip_of(input logic signed [31:0] lo,
            input logic signed [31:0] hi);
        logic signed [63:0] r;
        logic [63:0]        q;
        r = 64'(hi) - 64'(lo);
        if (r <= 0) return 48'd0;
        q = (64'd1 << 48) / 64'(r);
        return (q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
    endfunction

    function automatic logic [63:0] log2_q32(input logic [63:0] x);
        int          k;
        logic [63:0] m, f;
        if (x == 0) return 64'd0;
        k = 63;
        while (x[k] == 1'b0) k--;
        m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
        f = 64'd0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            if (m[63:32] != 0) begin
                m = m >> 1;
                f[31 - i] = 1'b1;
            end
        end
        return (64'(k) << 32) | f;
    endfunction

    function automatic logic [63:0] db_of(input logic [63:0] la, input logic [63:0] lb);
        logic         neg;
        logic [63:0]  d, r;
        logic [127:0] p;
        neg = la < lb;
        d = neg ? lb - la : la - lb;
        p = 128'(d) * 128'({DB_K1, DB_K0});
        r = p[95:32];
        return neg ? -r : r;
    endfunction

    function automatic metric_res_t mk_res(input logic [3:0] m, input logic [63:0] v,
            input logic [1:0] s, input logic f);
        metric_res_t x;
        x.metric = m; x.value = v; x.special = s; x.final_res = f;
        return x;
    endfunction

    task automatic clear_sums();
        for (int j = 0; j < 3; j++) begin
            p_sig[j] = 64'd0;
            p_err[j] = 64'd0;
        end
        p_count = '0;
    endtask

    task automatic reset_model();
        p_ref_low = Q_MAX; p_cmp_low = Q_MAX;
        p_ref_high = Q_MIN; p_cmp_high = Q_MIN;
        p_recip[0] = 48'd0; p_recip[1] = 48'd0;
        clear_sums();
    endtask

    task automatic predict_item(input logic op, input logic signed [31:0] r,
            input logic signed [31:0] c, input logic lst);
        logic signed [63:0] a[3], b[3];
        logic [63:0]        e, s, mse, ln, pk;
        logic [3:0]         base;
        logic               fin;
        pred_q.delete();
        if (op == OP_SCAN) begin
            if (p_count == 0) begin
                p_ref_low = Q_MAX; p_cmp_low = Q_MAX;
                p_ref_high = Q_MIN; p_cmp_high = Q_MIN;
            end
            if (r < p_ref_low)  p_ref_low  = r;
            if (r > p_ref_high) p_ref_high = r;
            if (c < p_cmp_low)  p_cmp_low  = c;
            if (c > p_cmp_high) p_cmp_high = c;
        end else begin
            a[0] = clamp_unit(norm_q(r, p_ref_low, p_recip[0]));
            b[0] = clamp_unit(norm_q(c, p_ref_low, p_recip[0]));
            a[1] = norm_q(r, p_ref_low, p_recip[0]);
            b[1] = norm_q(c, p_cmp_low, p_recip[1]);
            a[2] = 64'(r) <<< 16;
            b[2] = 64'(c) <<< 16;
            for (int j = 0; j < 3; j++) begin
                p_sig[j] = sat_add64(p_sig[j], sq_diff(a[j], 64'sd0));
                p_err[j] = sat_add64(p_err[j], sq_diff(a[j], b[j]));
            end
        end
        if (p_count < (25'd1 << 24)) p_count = p_count + 1'b1;
        if (!lst) return;
        if (op == OP_SCAN) begin
            pred_q.push_back(mk_res(MET_REF_MIN, 64'(p_ref_low), SPEC_FINITE, 1'b0));
            pred_q.push_back(mk_res(MET_REF_MIN + 4'd1, 64'(p_ref_high), SPEC_FINITE, 1'b0));
            pred_q.push_back(mk_res(MET_REF_MIN + 4'd2, 64'(p_cmp_low), SPEC_FINITE, 1'b0));
            pred_q.push_back(mk_res(MET_CMP_MAX, 64'(p_cmp_high), SPEC_FINITE, 1'b1));
            p_recip[0] = recip_of(p_ref_low, p_ref_high);
            p_recip[1] = recip_of(p_cmp_low, p_cmp_high);
            scan_ends++;
        end else begin
            ln = log2_q32(64'(p_count));
            for (int j = 0; j < 3; j++) begin
                e = p_err[j];
                s = p_sig[j];
                mse = e / 64'(p_count);
                base = MET_RULE_BASE + 4'(3 * j);
                fin = (j == 2);
                pred_q.push_back(mk_res(base, (mse > SAT_POS) ? SAT_POS : mse,
                                        SPEC_FINITE, 1'b0));
                if (e == 0) begin
                    pred_q.push_back(mk_res(base + 4'd1, SAT_POS, SPEC_POS_INF, 1'b0));
                    pred_q.push_back(mk_res(base + 4'd2, SAT_POS, SPEC_POS_INF, fin));
                end else begin
                    if (s == 0)
                        pred_q.push_back(mk_res(base + 4'd1, SAT_NEG, SPEC_NEG_INF, 1'b0));
                    else
                        pred_q.push_back(mk_res(base + 4'd1,
                            db_of(log2_q32(s), log2_q32(e)), SPEC_FINITE, 1'b0));
                    if (j < 2) begin
                        pred_q.push_back(mk_res(base + 4'd2,
                            db_of(ln + (64'd32 << 32), log2_q32(e)), SPEC_FINITE, fin));
                    end else begin
                        pk = (p_ref_high < 0) ? 64'(-64'(p_ref_high)) : 64'(p_ref_high);
                        if (pk == 0)
                            pred_q.push_back(mk_res(base + 4'd2, SAT_NEG, SPEC_NEG_INF, fin));
                        else
                            pred_q.push_back(mk_res(base + 4'd2,
                                db_of(log2_q32(pk * pk) + ln, log2_q32(e)),
                                SPEC_FINITE, fin));
                    end
                end
            end
            acc_ends++;
        end
        clear_sums();
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic signed [31:0] pick_sample(input int mode);
        case (mode)
            0: return $signed($urandom);
            1: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
            2: return $signed(32'($urandom_range(0, 2000))) - 32'sd1000;
            3: return $signed(32'($urandom_range(0, 200)) - 32'd100) <<< 16;
            default: return $signed(32'($urandom_range(0, 3)));
        endcase
    endfunction

    function automatic stim_row_t row(input logic op, input logic signed [31:0] r,
            input logic signed [31:0] c, input logic lst);
        stim_row_t x;
        x.op = op; x.ref_s = r; x.cmp_s = c; x.lst = lst; x.typed = 1'b0;
        x.t_rmin = 0; x.t_rmax = 0; x.t_cmin = 0; x.t_cmax = 0;
        return x;
    endfunction

    function automatic stim_row_t scan_end(input logic signed [31:0] r,
            input logic signed [31:0] c, input logic signed [31:0] rmin,
            input logic signed [31:0] rmax, input logic signed [31:0] cmin,
            input logic signed [31:0] cmax);
        stim_row_t x;
        x = row(OP_SCAN, r, c, 1'b1);
        x.typed = 1'b1;
        x.t_rmin = rmin; x.t_rmax = rmax; x.t_cmin = cmin; x.t_cmax = cmax;
        return x;
    endfunction

    task automatic send_row(input stim_row_t x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= x.op;
        in_ch.ref_sample <= x.ref_s;
        in_ch.cmp_sample <= x.cmp_s;
        in_ch.last       <= x.lst;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_item(x.op, x.ref_s, x.cmp_s, x.lst);
        if (x.typed) begin
            pending_res.push_back(mk_res(MET_REF_MIN, 64'(x.t_rmin), SPEC_FINITE, 1'b0));
            pending_res.push_back(mk_res(MET_REF_MIN + 4'd1, 64'(x.t_rmax),
                                         SPEC_FINITE, 1'b0));
            pending_res.push_back(mk_res(MET_REF_MIN + 4'd2, 64'(x.t_cmin),
                                         SPEC_FINITE, 1'b0));
            pending_res.push_back(mk_res(MET_CMP_MAX, 64'(x.t_cmax), SPEC_FINITE, 1'b1));
        end else begin
            foreach (pred_q[i]) pending_res.push_back(pred_q[i]);
        end
        items_sent++;
    endtask

    task automatic send_pass(input logic op, input int len, input int mode, input int rel);
        logic signed [31:0] r, c;
        for (int i = 0; i < len; i++) begin
            r = pick_sample(mode);
            case (rel)
                0: c = r;
                1: c = r + $signed(32'($urandom_range(0, 64)) - 32'd32);
                default: c = pick_sample(mode);
            endcase
            send_row(row(op, r, c, i == len - 1));
        end
    endtask

    // result side: random back-pressure, checking, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
            idle_cycles  <= 0;
        end else begin
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left   <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         pending_res.size());
                $display("tb_volume_error_metrics_top NOT OK");
                $finish;
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (pending_res.size() == 0) begin
                    unexpected++;
                    $display("unexpected result metric %0d value %h",
                             res_ch.metric, res_ch.value);
                end else begin
                    metric_res_t x;
                    x = pending_res.pop_front();
                    if (res_ch.metric !== x.metric || res_ch.value !== x.value ||
                        res_ch.special !== x.special || res_ch.final_res !== x.final_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp m%0d %h s%0d f%0d, got m%0d %h s%0d f%0d",
                                     x.metric, x.value, x.special, x.final_res,
                                     res_ch.metric, res_ch.value, res_ch.special,
                                     res_ch.final_res);
                    end
                end
            end
        end
    end

    initial begin
        int kind;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.opcode     <= OP_SCAN;
        in_ch.ref_sample <= '0;
        in_ch.cmp_sample <= '0;
        in_ch.last       <= 1'b0;
        mismatches = 0; unexpected = 0; results_seen = 0;
        items_sent = 0; scan_ends = 0; acc_ends = 0;
        reset_model();

        // after reset, zero ranges, unit range, no signal, zero peak, mixed pass
        dir_rows.push_back(row(OP_ACC, 32'sd0, 32'sd0, 1'b1));
        dir_rows.push_back(scan_end(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        dir_rows.push_back(row(OP_ACC, Q_MAX, Q_MIN, 1'b1));
        dir_rows.push_back(row(OP_SCAN, Q_MIN, Q_MIN, 1'b0));
        dir_rows.push_back(scan_end(Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        dir_rows.push_back(row(OP_ACC, Q_MIN, Q_MAX, 1'b0));
        dir_rows.push_back(row(OP_ACC, Q_MAX, Q_MIN, 1'b1));
        dir_rows.push_back(row(OP_ACC, 32'sd1234, 32'sd1234, 1'b1));
        dir_rows.push_back(row(OP_SCAN, 32'sd0, 32'sd0, 1'b0));
        dir_rows.push_back(scan_end(32'sd1, 32'sd1, 32'sd0, 32'sd1, 32'sd0, 32'sd1));
        dir_rows.push_back(row(OP_ACC, 32'sd1, 32'sd1, 1'b0));
        dir_rows.push_back(row(OP_ACC, 32'sd0, 32'sd1, 1'b1));
        dir_rows.push_back(row(OP_SCAN, -32'sd327680, 32'sd3, 1'b0));
        dir_rows.push_back(scan_end(32'sd0, 32'sd7, -32'sd327680, 32'sd0, 32'sd3, 32'sd7));
        dir_rows.push_back(row(OP_ACC, 32'sd0, 32'sd65536, 1'b1));
        dir_rows.push_back(row(OP_SCAN, 32'sd10, 32'sd20, 1'b0));
        dir_rows.push_back(row(OP_ACC, 32'sd15, 32'sd25, 1'b0));
        dir_rows.push_back(scan_end(32'sd30, 32'sd40, 32'sd10, 32'sd30, 32'sd20, 32'sd40));
        dir_rows.push_back(row(OP_ACC, 32'sd3, 32'sd5, 1'b0));
        dir_rows.push_back(row(OP_ACC, 32'sd40, 32'sd12, 1'b1));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_row(dir_rows[i]);

        while (items_sent < dir_rows.size() + N_RANDOM) begin
            if (items_sent >= dir_rows.size() + N_RANDOM / 2 && scan_ends < 100) begin
                in_ch.valid <= 1'b0;
                while (pending_res.size() != 0) @(posedge i_clk);
                scan_ends += 100;
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                int mode;
                mode = $urandom_range(0, 4);
                send_pass(OP_SCAN, $urandom_range(1, 5), mode, $urandom_range(0, 2));
                send_pass(OP_ACC, $urandom_range(1, 5), mode, $urandom_range(0, 2));
            end else if (kind == 7) begin
                send_row(row(OP_SCAN, pick_sample(2), pick_sample(2), 1'b0));
                send_row(row(OP_ACC, pick_sample(2), pick_sample(2), 1'b0));
                send_row(row(logic'($urandom_range(0, 1)), pick_sample(2),
                             pick_sample(2), 1'b1));
            end else if (kind == 8) begin
                send_pass(OP_ACC, $urandom_range(1, 4), $urandom_range(0, 4),
                          $urandom_range(0, 2));
            end else begin
                send_row(row(logic'($urandom_range(0, 1)), pick_sample(0), pick_sample(0),
                             logic'($urandom_range(0, 1))));
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d voxel items sent, %0d results checked", items_sent, results_seen);
        $display("%0d accumulate pass ends, %0d mismatches, %0d unexpected results",
                 acc_ends, mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && pending_res.size() == 0) begin
            $display("tb_volume_error_metrics_top OK");
        end else begin
            $display("tb_volume_error_metrics_top NOT OK");
        end
        $finish;
    end

endmodule
